// ----- src/adce_pkg.sv -----
// Shared types, constants and helpers for the ArtDMX channel extractor.
// No dependencies; used by the top level and its port checker.
package adce_pkg;

  localparam int unsigned POS_W = 10;

  localparam logic [POS_W-1:0] HDR_LEN       = 10'd18;
  localparam logic [POS_W-1:0] CAPTURE_LIMIT = 10'd550;
  localparam logic [POS_W-1:0] MAX_CHANNELS  = 10'd512;
  localparam logic [POS_W-1:0] ID_LEN        = 10'd8;

  localparam logic [POS_W-1:0] POS_OP_LO  = 10'd8;
  localparam logic [POS_W-1:0] POS_OP_HI  = 10'd9;
  localparam logic [POS_W-1:0] POS_SEQ    = 10'd12;
  localparam logic [POS_W-1:0] POS_UNI_LO = 10'd14;
  localparam logic [POS_W-1:0] POS_UNI_HI = 10'd15;
  localparam logic [POS_W-1:0] POS_LEN_HI = 10'd16;
  localparam logic [POS_W-1:0] POS_LEN_LO = 10'd17;

  localparam logic [15:0] OP_POLL = 16'h2000;
  localparam logic [15:0] OP_DMX  = 16'h5000;

  typedef enum logic [1:0] {
    OUT_IGNORED = 2'd0,
    OUT_POLL    = 2'd1,
    OUT_UPDATE  = 2'd2
  } outcome_t;

  typedef enum logic [2:0] {
    REG_LISTEN_ENABLE   = 3'd0,
    REG_LISTEN_UNIVERSE = 3'd1,
    REG_GATE_CHANNEL    = 3'd2,
    REG_GATE_THRESHOLD  = 3'd3,
    REG_AZ_COARSE       = 3'd4,
    REG_AZ_FINE         = 3'd5,
    REG_EL_COARSE       = 3'd6,
    REG_EL_FINE         = 3'd7
  } cfg_reg_t;

  // "Art-Net\0" identifier
  function automatic logic [7:0] art_id_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h41;
      3'd1:    b = 8'h72;
      3'd2:    b = 8'h74;
      3'd3:    b = 8'h2D;
      3'd4:    b = 8'h4E;
      3'd5:    b = 8'h65;
      3'd6:    b = 8'h74;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ----- src/artdmx_channel_extractor.sv -----
// ArtDMX channel extractor top level: byte parser, channel capture and result register.
// Depends on adce_pkg.
//
//  channel | signals                                   | beat
//  --------+-------------------------------------------+-------------------------------
//  in      | in_valid/in_ready                         | payload_byte, end_of_packet
//  out     | out_valid/out_ready                       | outcome, axis fields, seq, uni
//  cfg     | cfg_valid/cfg_ready                       | cfg_index, cfg_data
//
// One byte a cycle unless stalled. The byte is parsed into the packet registers as it
// is taken; on the end-marked byte the outcome is formed from the updated state and
// written to the result register at that same edge, so out_valid rises the next cycle.
// in_ready drops only while a result waits and out_ready is low. cfg_ready is always
// high. Synchronous reset clears the packet state, the configuration and out_valid.
module artdmx_channel_extractor
  import adce_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  payload_byte,
  input  logic        end_of_packet,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  outcome,
  output logic        az_present,
  output logic [15:0] az_position,
  output logic        el_present,
  output logic [15:0] el_position,
  output logic [7:0]  frame_sequence,
  output logic [15:0] frame_universe,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // configuration
  logic             listen_enable;
  logic [15:0]      listen_universe;
  logic [POS_W-1:0] gate_channel;
  logic [7:0]       gate_threshold;
  logic [POS_W-1:0] az_coarse_channel;
  logic [POS_W-1:0] az_fine_channel;
  logic [POS_W-1:0] el_coarse_channel;
  logic [POS_W-1:0] el_fine_channel;

  // packet state
  logic [POS_W-1:0] byte_position, byte_position_next;
  logic             header_match, header_match_next;
  logic [15:0]      rx_opcode, rx_opcode_next;
  logic [7:0]       rx_sequence, rx_sequence_next;
  logic [15:0]      rx_universe, rx_universe_next;
  logic [15:0]      rx_length, rx_length_next;
  logic [7:0]       captured_bytes [5];
  logic [7:0]       captured_bytes_next [5];

  // result register
  outcome_t         res_outcome, res_outcome_next;
  logic             res_az_present, res_az_present_next;
  logic [15:0]      res_az_position, res_az_position_next;
  logic             res_el_present, res_el_present_next;
  logic [15:0]      res_el_position, res_el_position_next;
  logic [7:0]       res_sequence, res_sequence_next;
  logic [15:0]      res_universe, res_universe_next;

  logic             in_fire;
  logic [POS_W-1:0] ch_num;
  logic [POS_W-1:0] rx_avail;
  logic [POS_W-1:0] eff_len;
  logic             long_enough;
  logic             gate_open;
  logic             az_has, el_has;
  logic [7:0]       az_lo, el_lo;
  logic             frame_ok;

  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      listen_enable     <= 1'b0;
      listen_universe   <= '0;
      gate_channel      <= '0;
      gate_threshold    <= '0;
      az_coarse_channel <= '0;
      az_fine_channel   <= '0;
      el_coarse_channel <= '0;
      el_fine_channel   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LISTEN_ENABLE:   listen_enable     <= cfg_data[0];
        REG_LISTEN_UNIVERSE: listen_universe   <= cfg_data;
        REG_GATE_CHANNEL:    gate_channel      <= cfg_data[POS_W-1:0];
        REG_GATE_THRESHOLD:  gate_threshold    <= cfg_data[7:0];
        REG_AZ_COARSE:       az_coarse_channel <= cfg_data[POS_W-1:0];
        REG_AZ_FINE:         az_fine_channel   <= cfg_data[POS_W-1:0];
        REG_EL_COARSE:       el_coarse_channel <= cfg_data[POS_W-1:0];
        REG_EL_FINE:         el_fine_channel   <= cfg_data[POS_W-1:0];
      endcase
    end
  end

  // byte parser
  assign ch_num = byte_position - (HDR_LEN - 10'd1);

  always_comb begin
    byte_position_next = byte_position;
    header_match_next  = header_match;
    rx_opcode_next     = rx_opcode;
    rx_sequence_next   = rx_sequence;
    rx_universe_next   = rx_universe;
    rx_length_next     = rx_length;
    for (int i = 0; i < 5; i++) captured_bytes_next[i] = captured_bytes[i];
    if (byte_position < CAPTURE_LIMIT) begin
      byte_position_next = byte_position + 10'd1;
      if (byte_position < ID_LEN) begin
        if (payload_byte != art_id_byte(byte_position[2:0])) header_match_next = 1'b0;
      end else begin
        unique case (byte_position)
          POS_OP_LO:  rx_opcode_next[7:0]    = payload_byte;
          POS_OP_HI:  rx_opcode_next[15:8]   = payload_byte;
          POS_SEQ:    rx_sequence_next       = payload_byte;
          POS_UNI_LO: rx_universe_next[7:0]  = payload_byte;
          POS_UNI_HI: rx_universe_next[15:8] = payload_byte;
          POS_LEN_HI: rx_length_next[15:8]   = payload_byte;
          POS_LEN_LO: rx_length_next[7:0]    = payload_byte;
          default: begin
            if (byte_position >= HDR_LEN) begin
              if (ch_num == gate_channel)      captured_bytes_next[0] = payload_byte;
              if (ch_num == az_coarse_channel) captured_bytes_next[1] = payload_byte;
              if (ch_num == az_fine_channel)   captured_bytes_next[2] = payload_byte;
              if (ch_num == el_coarse_channel) captured_bytes_next[3] = payload_byte;
              if (ch_num == el_fine_channel)   captured_bytes_next[4] = payload_byte;
            end
          end
        endcase
      end
    end
  end

  // outcome from the state after this byte
  assign long_enough = byte_position_next >= HDR_LEN;
  assign rx_avail    = long_enough ? (byte_position_next - HDR_LEN) : '0;

  always_comb begin
    eff_len = rx_avail;
    if (rx_length_next < {6'd0, rx_avail}) eff_len = rx_length_next[POS_W-1:0];
    if (eff_len > MAX_CHANNELS) eff_len = MAX_CHANNELS;
  end

  assign gate_open = (gate_channel == '0) ||
                     ((gate_channel <= eff_len) && (captured_bytes_next[0] >= gate_threshold));
  assign az_has = (az_coarse_channel != '0) && (az_coarse_channel <= eff_len);
  assign el_has = (el_coarse_channel != '0) && (el_coarse_channel <= eff_len);
  assign az_lo  = ((az_fine_channel != '0) && (az_fine_channel <= eff_len)) ?
                  captured_bytes_next[2] : 8'd0;
  assign el_lo  = ((el_fine_channel != '0) && (el_fine_channel <= eff_len)) ?
                  captured_bytes_next[4] : 8'd0;
  assign frame_ok = listen_enable && long_enough && header_match_next;

  always_comb begin
    res_outcome_next     = OUT_IGNORED;
    res_az_present_next  = 1'b0;
    res_az_position_next = '0;
    res_el_present_next  = 1'b0;
    res_el_position_next = '0;
    res_sequence_next    = '0;
    res_universe_next    = '0;
    if (frame_ok) begin
      if (rx_opcode_next == OP_POLL) begin
        res_outcome_next = OUT_POLL;
      end else if (rx_opcode_next == OP_DMX && rx_universe_next == listen_universe &&
                   gate_open && (az_has || el_has)) begin
        res_outcome_next     = OUT_UPDATE;
        res_az_present_next  = az_has;
        res_az_position_next = az_has ? {captured_bytes_next[1], az_lo} : 16'd0;
        res_el_present_next  = el_has;
        res_el_position_next = el_has ? {captured_bytes_next[3], el_lo} : 16'd0;
        res_sequence_next    = rx_sequence_next;
        res_universe_next    = rx_universe_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      header_match  <= 1'b1;
      rx_opcode     <= '0;
      rx_sequence   <= '0;
      rx_universe   <= '0;
      rx_length     <= '0;
      for (int i = 0; i < 5; i++) captured_bytes[i] <= '0;
    end else if (in_fire) begin
      if (end_of_packet) begin
        byte_position <= '0;
        header_match  <= 1'b1;
        rx_opcode     <= '0;
        rx_sequence   <= '0;
        rx_universe   <= '0;
        rx_length     <= '0;
        for (int i = 0; i < 5; i++) captured_bytes[i] <= '0;
      end else begin
        byte_position <= byte_position_next;
        header_match  <= header_match_next;
        rx_opcode     <= rx_opcode_next;
        rx_sequence   <= rx_sequence_next;
        rx_universe   <= rx_universe_next;
        rx_length     <= rx_length_next;
        for (int i = 0; i < 5; i++) captured_bytes[i] <= captured_bytes_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && end_of_packet) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && end_of_packet) begin
      res_outcome     <= res_outcome_next;
      res_az_present  <= res_az_present_next;
      res_az_position <= res_az_position_next;
      res_el_present  <= res_el_present_next;
      res_el_position <= res_el_position_next;
      res_sequence    <= res_sequence_next;
      res_universe    <= res_universe_next;
    end
  end

  assign outcome        = res_outcome;
  assign az_present     = res_az_present;
  assign az_position    = res_az_position;
  assign el_present     = res_el_present;
  assign el_position    = res_el_position;
  assign frame_sequence = res_sequence;
  assign frame_universe = res_universe;

endmodule

// ----- src/adce_checker.sv -----
// Port-level checker for the ArtDMX channel extractor, bound to the top level.
// Depends on adce_pkg.
module adce_checker
  import adce_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  outcome,
  input logic        az_present,
  input logic [15:0] az_position,
  input logic        el_present,
  input logic [15:0] el_position,
  input logic [7:0]  frame_sequence,
  input logic [15:0] frame_universe
);

  // a waiting result holds its outcome, positions and universe
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(outcome) &&
      $stable(az_position) && $stable(el_position) && $stable(frame_universe))
    else $error("result changed while stalled");

  // non-update beats carry only zeros
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (outcome == OUT_IGNORED || outcome == OUT_POLL) |->
      !az_present && !el_present && az_position == 16'd0 && el_position == 16'd0 &&
      frame_sequence == 8'd0 && frame_universe == 16'd0)
    else $error("stray field on non-update result");

  // an update has at least one axis, and absent axes read zero
  a_update_axes: assert property (@(posedge clk) disable iff (rst)
    out_valid && outcome == OUT_UPDATE |-> (az_present || el_present) &&
      (az_present || az_position == 16'd0) && (el_present || el_position == 16'd0))
    else $error("bad axis fields on update");

  // input is held off only by a stalled result
  a_in_ready: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without cause");

endmodule

bind artdmx_channel_extractor adce_checker u_adce_checker (.*);
